/* sv/dad_pkg.sv */
package dad_pkg;

  // calendar limits and field widths
  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 16;
  localparam int DAY_W       = 5;
  localparam int MON_W       = 4;
  localparam int YEAR_W      = 14;
  localparam int STAT_W      = 2;

  // working day count: offset plus day of year, with sign
  localparam int T_W = OFFSET_BITS + 2;

  // reciprocal of 100 for 14-bit years: q = (y * RECIP_100) >> RECIP_SHIFT
  localparam int PROD_W      = 27;
  localparam int RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100 = 13'd5243;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RES,
    S_CHECK,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic res;
    logic check;
    logic yr_dec;
    logic yr_inc;
    logic mon_first;
    logic mon_step;
    logic err_date;
    logic err_range;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic date_ok;
    logic t_neg;
    logic t_over;
    logic y_min;
    logic y_max;
    logic mon_more;
  } dp_stat_t;

  function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

/* sv/dad_ctrl.sv */
module dad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dad_pkg::dp_stat_t stat,
  output dad_pkg::dp_cmd_t  cmd
);

  dad_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dad_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == dad_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      dad_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = dad_pkg::S_MUL;
        end
      end
      dad_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = dad_pkg::S_RES;
      end
      dad_pkg::S_RES: begin
        cmd.res   = 1'b1;
        state_nxt = dad_pkg::S_CHECK;
      end
      dad_pkg::S_CHECK: begin
        if (stat.date_ok) begin
          cmd.check = 1'b1;
          state_nxt = dad_pkg::S_YEAR;
        end else begin
          cmd.err_date = 1'b1;
          state_nxt    = dad_pkg::S_DONE;
        end
      end
      dad_pkg::S_YEAR: begin
        if (stat.t_neg) begin
          if (stat.y_min) begin
            cmd.err_range = 1'b1;
            state_nxt     = dad_pkg::S_DONE;
          end else begin
            cmd.yr_dec = 1'b1;
          end
        end else if (stat.t_over) begin
          if (stat.y_max) begin
            cmd.err_range = 1'b1;
            state_nxt     = dad_pkg::S_DONE;
          end else begin
            cmd.yr_inc = 1'b1;
          end
        end else begin
          cmd.mon_first = 1'b1;
          state_nxt     = dad_pkg::S_MONTH;
        end
      end
      dad_pkg::S_MONTH: begin
        if (stat.mon_more) begin
          cmd.mon_step = 1'b1;
        end else begin
          state_nxt = dad_pkg::S_DONE;
        end
      end
      dad_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = dad_pkg::S_IDLE;
        end
      end
      default: state_nxt = dad_pkg::S_IDLE;
    endcase
  end

  // result flag: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

/* sv/dad_datapath.sv */
module dad_datapath (
  input  logic                              clk,
  input  logic [dad_pkg::DAY_W-1:0]         start_day,
  input  logic [dad_pkg::MON_W-1:0]         start_month,
  input  logic [dad_pkg::YEAR_W-1:0]        start_year,
  input  logic signed [dad_pkg::OFFSET_BITS-1:0] day_offset,
  input  dad_pkg::dp_cmd_t                  cmd,
  output dad_pkg::dp_stat_t                 stat,
  output logic [dad_pkg::DAY_W-1:0]         result_day,
  output logic [dad_pkg::MON_W-1:0]         result_month,
  output logic [dad_pkg::YEAR_W-1:0]        result_year,
  output dad_pkg::status_t                  status
);

  localparam int T_W = dad_pkg::T_W;

  logic [dad_pkg::DAY_W-1:0]       day_r;
  logic [dad_pkg::MON_W-1:0]       mon_r;
  logic [dad_pkg::YEAR_W-1:0]      year_r;
  logic [dad_pkg::OFFSET_BITS-1:0] off_r;
  logic [dad_pkg::PROD_W-1:0]      prod_r;
  logic [6:0]                      r100_r;
  logic [1:0]                      q_r;
  logic [dad_pkg::YEAR_W-1:0]      y_r;
  logic [T_W-1:0]                  t_r;
  logic [dad_pkg::MON_W-1:0]       m_r;
  dad_pkg::status_t                status_r;
  logic [dad_pkg::DAY_W-1:0]       od_r;
  logic [dad_pkg::MON_W-1:0]       om_r;
  logic [dad_pkg::YEAR_W-1:0]      oy_r;
  dad_pkg::status_t                os_r;

  logic                            leap_cur, leap_dec;
  logic [dad_pkg::YEAR_W-1:0]      y_dec;
  logic [6:0]                      r_dec, r_inc;
  logic [1:0]                      q_dec, q_inc;
  logic [7:0]                      q_full;
  logic [dad_pkg::YEAR_W-1:0]      r_full;
  logic [4:0]                      mlen_start, mlen_cur;
  logic [8:0]                      doy;
  logic [T_W-1:0]                  off_ext, t_start;
  logic [8:0]                      ylen_cur, ylen_dec;

  // leap rule from year mod 4, mod 100 and quotient mod 4
  assign leap_cur = (y_r[1:0] == 2'd0) && ((r100_r != 7'd0) || (q_r == 2'd0));

  // residues of the year before and after
  assign y_dec = y_r - 1'b1;
  assign r_dec = (r100_r == 7'd0) ? 7'd99 : r100_r - 7'd1;
  assign q_dec = (r100_r == 7'd0) ? q_r - 2'd1 : q_r;
  assign r_inc = (r100_r == 7'd99) ? 7'd0 : r100_r + 7'd1;
  assign q_inc = (r100_r == 7'd99) ? q_r + 2'd1 : q_r;
  assign leap_dec = (y_dec[1:0] == 2'd0) && ((r_dec != 7'd0) || (q_dec == 2'd0));

  assign ylen_cur = dad_pkg::year_len(leap_cur);
  assign ylen_dec = dad_pkg::year_len(leap_dec);

  // quotient and remainder of the start year by 100
  assign q_full = prod_r[dad_pkg::PROD_W-1:dad_pkg::RECIP_SHIFT];
  assign r_full = year_r - dad_pkg::YEAR_W'(q_full * 7'd100);

  // start date check and day count from january 1
  assign mlen_start = dad_pkg::month_len(mon_r, leap_cur);
  assign doy = dad_pkg::cum_days(mon_r)
             + 9'((leap_cur && (mon_r > dad_pkg::MON_W'(2))) ? 1 : 0)
             + 9'(day_r) - 9'd1;
  assign off_ext = {{(T_W-dad_pkg::OFFSET_BITS){off_r[dad_pkg::OFFSET_BITS-1]}}, off_r};
  assign t_start = off_ext + T_W'(doy);

  assign mlen_cur = dad_pkg::month_len(m_r, leap_cur);

  always_comb begin
    stat.date_ok  = (mon_r inside {[4'd1:4'd12]})
                  && (y_r >= dad_pkg::YEAR_W'(1))
                  && (y_r <= dad_pkg::YEAR_W'(dad_pkg::MAX_YEAR))
                  && (day_r >= dad_pkg::DAY_W'(1))
                  && (day_r <= mlen_start);
    stat.t_neg    = t_r[T_W-1];
    stat.t_over   = !t_r[T_W-1] && (t_r >= T_W'(ylen_cur));
    stat.y_min    = (y_r == dad_pkg::YEAR_W'(1));
    stat.y_max    = (y_r == dad_pkg::YEAR_W'(dad_pkg::MAX_YEAR));
    stat.mon_more = (m_r < dad_pkg::MON_W'(12)) && (t_r >= T_W'(mlen_cur));
  end

  // capture and constant multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r  <= start_day;
      mon_r  <= start_month;
      year_r <= start_year;
      off_r  <= day_offset;
    end
    if (cmd.mul) begin
      prod_r <= dad_pkg::PROD_W'(year_r) * dad_pkg::PROD_W'(dad_pkg::RECIP_100);
    end
  end

  // year walk, month walk and status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r <= start_year;
    end
    if (cmd.res) begin
      r100_r <= r_full[6:0];
      q_r    <= q_full[1:0];
    end
    if (cmd.check) begin
      t_r      <= t_start;
      status_r <= dad_pkg::ST_OK;
    end
    if (cmd.err_date) begin
      status_r <= dad_pkg::ST_BAD_DATE;
    end
    if (cmd.err_range) begin
      status_r <= dad_pkg::ST_RANGE;
    end
    if (cmd.yr_dec) begin
      y_r    <= y_dec;
      r100_r <= r_dec;
      q_r    <= q_dec;
      t_r    <= t_r + T_W'(ylen_dec);
    end
    if (cmd.yr_inc) begin
      y_r    <= y_r + 1'b1;
      r100_r <= r_inc;
      q_r    <= q_inc;
      t_r    <= t_r - T_W'(ylen_cur);
    end
    if (cmd.mon_first) begin
      m_r <= dad_pkg::MON_W'(1);
    end
    if (cmd.mon_step) begin
      m_r <= m_r + 1'b1;
      t_r <= t_r - T_W'(mlen_cur);
    end
  end

  // result register, echoes the start date on error
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      os_r <= status_r;
      if (status_r == dad_pkg::ST_OK) begin
        od_r <= t_r[dad_pkg::DAY_W-1:0] + 1'b1;
        om_r <= m_r;
        oy_r <= y_r;
      end else begin
        od_r <= day_r;
        om_r <= mon_r;
        oy_r <= year_r;
      end
    end
  end

  assign result_day   = od_r;
  assign result_month = om_r;
  assign result_year  = oy_r;
  assign status       = os_r;

endmodule

/* sv/date_add_days_unit.sv */
// Gregorian date adder: takes a start date and a signed day offset and returns the
// date that lies that many days away, carrying across month and year ends in both
// directions. An invalid start date gives status 1 and a result before year 1 or
// after year 9999 gives status 2; in both cases the start date comes back unchanged.
// One request is worked on at a time. After setup (capture, multiply, residue and
// check), the year walk takes one step for each year crossed (about |offset|/365, at
// most 90) and the month walk one step for each month stepped (at most 11); then the
// result register is loaded. A bad start date skips both walks.
// A finished result waits in the output register while the next request is taken.
module date_add_days_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], day_offset[38:23], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9], zero fill
  output logic [23:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser
);

  dad_pkg::dp_cmd_t             cmd;
  dad_pkg::dp_stat_t            stat;
  logic [dad_pkg::DAY_W-1:0]    result_day;
  logic [dad_pkg::MON_W-1:0]    result_month;
  logic [dad_pkg::YEAR_W-1:0]   result_year;
  dad_pkg::status_t             status;

  // sequencer
  dad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // date arithmetic
  dad_datapath u_dp (
    .clk          (clk),
    .start_day    (in_tdata[4:0]),
    .start_month  (in_tdata[8:5]),
    .start_year   (in_tdata[22:9]),
    .day_offset   (in_tdata[38:23]),
    .cmd          (cmd),
    .stat         (stat),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .status       (status)
  );

  assign out_tdata = {1'b0, result_year, result_month, result_day};
  assign out_tuser = status;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in progress");

  // a good result is a proper calendar date
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status == dad_pkg::ST_OK)) |->
      (result_month >= 4'd1) && (result_month <= 4'd12) && (result_day >= 5'd1)
      && (result_year >= 14'd1) && (result_year <= 14'(dad_pkg::MAX_YEAR)))
    else $error("result date out of range with ok status");

  // a result is loaded only on the way back to idle
  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (in_tready && out_tvalid))
    else $error("result load not followed by idle with valid output");

endmodule
